FILE: rtl/core/tcp_pkg.sv
// Shared types and constants of the transfer chunk planner.
`timescale 1ns / 1ps
`default_nettype none

package tcp_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_REGION_BASE = 3'd0;
    localparam logic [2:0] REG_REGION_SIZE = 3'd1;
    localparam logic [2:0] REG_NODE_COUNT  = 3'd2;
    localparam logic [2:0] REG_LOCAL_NODE  = 3'd3;
    localparam logic [2:0] REG_MAX_CHUNK   = 3'd4;

    // Transfer kinds carried in the query.
    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_COPY = 2'd1;
    localparam logic [1:0] MODE_MOVE = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration and the values derived from it, as seen by the datapath.
    typedef struct packed {
        logic [63:0] region_base;
        logic [63:0] region_size;
        logic [63:0] rgn_end;
        logic [63:0] node_span;
        logic [63:0] last_off;     // offset of the last node inside the region
        logic [15:0] node_count;
        logic [15:0] local_node;
        logic [31:0] max_chunk;
        logic        ok;           // configuration can produce chunks
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcp_cfg.sv
// Configuration registers and the sequential divider that derives the node size.
`timescale 1ns / 1ps
`default_nettype none

module tcp_cfg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output tcp_pkg::cfg_t    cfg_o
);
    import tcp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t      state_reg;
    logic [63:0] base_reg, size_reg;
    logic [15:0] count_reg, local_reg;
    logic [31:0] max_reg;
    logic [63:0] end_reg, nsize_reg, last_reg;
    logic        ok_reg;
    logic [16:0] rem_reg;
    logic [63:0] quo_reg;
    logic [6:0]  cnt_reg;

    logic        wr;
    logic [16:0] trial;
    logic        take;
    logic [64:0] end_sum;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign wr        = cfg_valid && cfg_ready;

    // One quotient bit per cycle of region_size / node_count.
    assign trial   = {rem_reg[15:0], quo_reg[63]};
    assign take    = (trial >= {1'b0, count_reg});
    assign end_sum = {1'b0, base_reg} + {1'b0, size_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            size_reg  <= '0;
            count_reg <= 16'd1;
            local_reg <= '0;
            max_reg   <= 32'd65536;
            end_reg   <= '0;
            nsize_reg <= '0;
            last_reg  <= '0;
            ok_reg    <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (wr) begin
                        case (cfg_index)
                            REG_REGION_BASE: base_reg  <= cfg_data;
                            REG_REGION_SIZE: size_reg  <= cfg_data;
                            REG_NODE_COUNT:  count_reg <= cfg_data[15:0];
                            REG_LOCAL_NODE:  local_reg <= cfg_data[15:0];
                            REG_MAX_CHUNK:   max_reg   <= cfg_data[31:0];
                            default: ;
                        endcase
                        quo_reg   <= (cfg_index == REG_REGION_SIZE) ? cfg_data : size_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= 7'd64;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= take ? (trial - {1'b0, count_reg}) : trial;
                    quo_reg <= {quo_reg[62:0], take};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // Remainder and quotient give the start of the last node.
                    nsize_reg <= quo_reg;
                    end_reg   <= end_sum[63:0];
                    last_reg  <= size_reg - {48'd0, rem_reg[15:0]} - quo_reg;
                    ok_reg    <= (size_reg != 64'd0) && (count_reg != 16'd0)
                                 && (local_reg < count_reg) && !end_sum[64]
                                 && (quo_reg != 64'd0);
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cfg_o.region_base = base_reg;
        cfg_o.region_size = size_reg;
        cfg_o.rgn_end     = end_reg;
        cfg_o.node_span   = nsize_reg;
        cfg_o.last_off    = last_reg;
        cfg_o.node_count  = count_reg;
        cfg_o.local_node  = local_reg;
        cfg_o.max_chunk   = max_reg;
        cfg_o.ok          = ok_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/transfer_chunk_planner.sv
// Top level of the transfer chunk planner: a pipelined chunk calculation.
`timescale 1ns / 1ps
`default_nettype none

// The planner answers each transfer query with exactly one result beat. The
// datapath is a 23-stage pipeline that accepts one query per cycle when not
// stalled and presents its result beat from its last stage, E; the length is
// set by the 17 stages of the restoring divider that finds the node of each
// endpoint, one quotient bit per stage. A stage moves on whenever the next
// stage is empty or moving, so bubbles collapse under back-pressure. After
// each configuration write the node size is recomputed by a serial divider,
// during which neither queries nor further writes are accepted.
module transfer_chunk_planner (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Query: mode[1:0], destination[65:2], source[129:66],
    // xfer_len[193:130], completed[257:194], zero fill up to bit 263.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [263:0] s_tdata,
    // Result: chunk_valid[0], status[1], chunk_destination[65:2],
    // chunk_source[129:66], chunk_length[161:130], dst_node[177:162],
    // src_node[193:178], dst_remote[194], src_remote[195],
    // zero fill up to bit 199.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [199:0]      m_tdata,
    // Configuration writes.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import tcp_pkg::*;

    localparam int NSTG   = 23;
    localparam int QBITS  = 17;
    localparam int DIV0   = 2;
    localparam int ST_C   = DIV0 + QBITS;
    localparam int ST_D1  = ST_C + 1;
    localparam int ST_D2  = ST_C + 2;
    localparam int ST_E   = ST_C + 3;

    typedef struct packed {
        logic              in_region;
        logic [63:0]       room;
        logic [63:0]       off;
        logic [63:0]       r;
        logic [QBITS-1:0]  q;
        logic [15:0]       node;
        logic              remote;
    } ep_t;

    typedef struct packed {
        logic        drop;
        logic        status;
        logic        is_set;
        logic        backward;
        logic [63:0] rem;
        logic [63:0] cdst;
        logic [63:0] csrc;
        logic [63:0] dlim;
        logic [63:0] slim;
        logic [63:0] lim;
        ep_t         d;
        ep_t         s;
    } pl_t;

    cfg_t cfg;

    pl_t  p_reg  [NSTG];
    pl_t  p_next [NSTG];
    logic v_reg  [NSTG];
    logic load   [NSTG];

    // Endpoint classification against the region.
    function automatic ep_t classify(input logic active, input logic bwd,
                                     input logic [63:0] addr, input logic [63:0] limit,
                                     input cfg_t c);
        ep_t         e;
        logic [63:0] a;
        e        = '0;
        e.room   = '1;
        e.node   = c.local_node;
        a        = bwd ? (limit - 64'd1) : addr;
        if (active) begin
            if (bwd && limit == 64'd0) begin
                e.room = '0;
            end else if (a < c.region_base) begin
                e.room = bwd ? limit : (c.region_base - a);
            end else if (a >= c.rgn_end) begin
                e.room = bwd ? (limit - c.rgn_end) : '1;
            end else begin
                e.in_region = 1'b1;
                e.off       = a - c.region_base;
                e.r         = a - c.region_base;
            end
        end
        return e;
    endfunction

    // One restoring division step for quotient bit i.
    function automatic ep_t div_step(input ep_t e, input logic [63:0] ns, input int i);
        ep_t         o;
        logic [80:0] sh;
        o  = e;
        sh = {17'd0, ns} << i;
        if (e.in_region && ({17'd0, e.r} >= sh)) begin
            o.r    = e.r - sh[63:0];
            o.q[i] = 1'b1;
        end
        return o;
    endfunction

    // Node number and distance to the node edge in the chunk direction.
    function automatic ep_t finish(input ep_t e, input logic bwd, input cfg_t c);
        ep_t         o;
        logic [16:0] cnt;
        logic        last;
        o   = e;
        cnt = {1'b0, c.node_count};
        if (e.in_region) begin
            last   = (e.q >= cnt - 17'd1);
            o.node = (e.q >= cnt) ? (c.node_count - 16'd1) : e.q[15:0];
            if (bwd) begin
                o.room = last ? (e.off - c.last_off + 64'd1) : (e.r + 64'd1);
            end else begin
                o.room = last ? (c.region_size - e.off) : (c.node_span - e.r);
            end
            o.remote = (o.node != c.local_node);
        end
        return o;
    endfunction

    tcp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // Flow control: a stage loads when it is empty or its content moves on.
    always_comb begin
        load[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            load[k] = !v_reg[k] || load[k+1];
        end
    end

    assign s_tready = load[0] && cfg_ready;

    // Stage A: overflow, direction and the running addresses.
    always_comb begin
        logic [1:0]  mode;
        logic [63:0] dst, src, total, done;
        logic [64:0] sum_d, sum_s;
        logic        ovf;
        mode  = s_tdata[1:0];
        dst   = s_tdata[65:2];
        src   = s_tdata[129:66];
        total = s_tdata[193:130];
        done  = s_tdata[257:194];
        sum_d = {1'b0, dst} + {1'b0, total};
        sum_s = {1'b0, src} + {1'b0, total};
        p_next[0]          = '0;
        p_next[0].is_set   = (mode == MODE_SET);
        ovf                = sum_d[64] || (!p_next[0].is_set && sum_s[64]);
        p_next[0].status   = (mode != MODE_NONE) && ovf;
        p_next[0].backward = (mode == MODE_MOVE) && (dst > src) && (dst < sum_s[63:0]);
        p_next[0].drop     = (mode == MODE_NONE) || ovf || (done >= total)
                             || (cfg.max_chunk == 32'd0) || !cfg.ok;
        p_next[0].rem      = total - done;
        p_next[0].cdst     = dst + done;
        p_next[0].csrc     = p_next[0].is_set ? 64'd0 : (src + done);
        p_next[0].dlim     = dst + p_next[0].rem;
        p_next[0].slim     = src + p_next[0].rem;
    end

    // Stage B: place both endpoints relative to the region.
    always_comb begin
        p_next[1]   = p_reg[0];
        p_next[1].d = classify(1'b1, p_reg[0].backward, p_reg[0].cdst, p_reg[0].dlim, cfg);
        p_next[1].s = classify(!p_reg[0].is_set, p_reg[0].backward, p_reg[0].csrc,
                               p_reg[0].slim, cfg);
    end

    // Divider stages, most significant quotient bit first.
    for (genvar g = 0; g < QBITS; g++) begin : g_div
        always_comb begin
            p_next[DIV0+g]   = p_reg[DIV0+g-1];
            p_next[DIV0+g].d = div_step(p_reg[DIV0+g-1].d, cfg.node_span, QBITS - 1 - g);
            p_next[DIV0+g].s = div_step(p_reg[DIV0+g-1].s, cfg.node_span, QBITS - 1 - g);
        end
    end

    // Stage C: nodes and edge distances.
    always_comb begin
        p_next[ST_C]   = p_reg[ST_C-1];
        p_next[ST_C].d = finish(p_reg[ST_C-1].d, p_reg[ST_C-1].backward, cfg);
        p_next[ST_C].s = finish(p_reg[ST_C-1].s, p_reg[ST_C-1].backward, cfg);
    end

    // Stage D1: pairwise minimums.
    always_comb begin
        p_next[ST_D1]     = p_reg[ST_C];
        p_next[ST_D1].lim = ({32'd0, cfg.max_chunk} < p_reg[ST_C].rem)
                            ? {32'd0, cfg.max_chunk} : p_reg[ST_C].rem;
        p_next[ST_D1].d.room = (p_reg[ST_C].d.room < p_reg[ST_C].s.room)
                               ? p_reg[ST_C].d.room : p_reg[ST_C].s.room;
    end

    // Stage D2: final chunk length and its range check.
    always_comb begin
        p_next[ST_D2]     = p_reg[ST_D1];
        p_next[ST_D2].lim = (p_reg[ST_D1].lim < p_reg[ST_D1].d.room)
                            ? p_reg[ST_D1].lim : p_reg[ST_D1].d.room;
        p_next[ST_D2].drop = p_reg[ST_D1].drop || (p_next[ST_D2].lim == 64'd0)
                             || (p_next[ST_D2].lim[63:32] != 32'd0);
    end

    // Stage E: chunk start addresses; a dropped query shows only its status.
    always_comb begin
        p_next[ST_E] = p_reg[ST_D2];
        if (p_reg[ST_D2].drop) begin
            p_next[ST_E]        = '0;
            p_next[ST_E].drop   = 1'b1;
            p_next[ST_E].status = p_reg[ST_D2].status;
        end else if (p_reg[ST_D2].backward) begin
            p_next[ST_E].cdst = p_reg[ST_D2].dlim - p_reg[ST_D2].lim;
            p_next[ST_E].csrc = p_reg[ST_D2].slim - p_reg[ST_D2].lim;
        end
    end

    // Pipeline registers with valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (load[0]) begin
            v_reg[0] <= s_tvalid && s_tready;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (load[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
        for (int k = 0; k < NSTG; k++) begin
            if (load[k]) begin
                p_reg[k] <= p_next[k];
            end
        end
    end

    // Result beat.
    assign m_tvalid = v_reg[ST_E];
    assign m_tdata  = {4'd0,
                       p_reg[ST_E].s.remote,
                       p_reg[ST_E].d.remote,
                       p_reg[ST_E].s.node,
                       p_reg[ST_E].d.node,
                       p_reg[ST_E].lim[31:0],
                       p_reg[ST_E].csrc,
                       p_reg[ST_E].cdst,
                       p_reg[ST_E].status,
                       !p_reg[ST_E].drop};

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench of the transfer chunk planner: directed and random queries checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import tcp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] completed;
        logic [63:0] xfer_len;
        logic [63:0] source;
        logic [63:0] destination;
        logic [1:0]  mode;
    } query_t;

    typedef struct packed {
        logic        src_remote;
        logic        dst_remote;
        logic [15:0] src_node;
        logic [15:0] dst_node;
        logic [31:0] chunk_length;
        logic [63:0] chunk_source;
        logic [63:0] chunk_destination;
        logic        status;
        logic        chunk_valid;
    } chunk_t;

    typedef struct {
        logic [15:0] node;
        logic        remote;
        logic [63:0] room;
    } endpoint_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [263:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    // Predictor copy of the configuration registers.
    logic [63:0] pl_base = '0;
    logic [63:0] pl_size = '0;
    logic [15:0] pl_nodes = 16'd1;
    logic [15:0] pl_local = '0;
    logic [31:0] pl_max = 32'd65536;

    chunk_t expected_chunks[$];
    int     mismatch_count = 0;
    int     sender_idle = 0;
    int     receiver_idle = 0;
    int     hold_cycles = 0;
    int     quiet_cycles = 0;

    always #1 aclk = ~aclk;

    transfer_chunk_planner i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [63:0] node_index(logic [63:0] addr, logic [63:0] nsz);
        logic [63:0] n;
        n = (addr - pl_base) / nsz;
        if (n >= {48'd0, pl_nodes}) n = {48'd0, pl_nodes} - 64'd1;
        return n;
    endfunction

    // Endpoint whose chunk grows upward from addr.
    function automatic endpoint_t reach_up(logic [63:0] rend, logic [63:0] nsz,
                                           logic [63:0] addr);
        endpoint_t r;
        logic [63:0] n, top;
        r.node = pl_local; r.remote = 1'b0; r.room = ALL_ONES;
        if (addr < pl_base) begin
            r.room = pl_base - addr;
        end else if (addr < rend) begin
            n = node_index(addr, nsz);
            top = (n + 64'd1 == {48'd0, pl_nodes}) ? rend : pl_base + (n + 64'd1) * nsz;
            r.node = n[15:0];
            r.remote = (n[15:0] != pl_local);
            r.room = top - addr;
        end
        return r;
    endfunction

    // Endpoint whose chunk ends just below limit and grows downward.
    function automatic endpoint_t reach_down(logic [63:0] rend, logic [63:0] nsz,
                                             logic [63:0] limit);
        endpoint_t r;
        logic [63:0] addr, n;
        r.node = pl_local; r.remote = 1'b0; r.room = ALL_ONES;
        addr = limit - 64'd1;
        if (limit == 64'd0) begin
            r.room = 64'd0;
        end else if (addr < pl_base) begin
            r.room = limit;
        end else if (addr >= rend) begin
            r.room = limit - rend;
        end else begin
            n = node_index(addr, nsz);
            r.node = n[15:0];
            r.remote = (n[15:0] != pl_local);
            r.room = limit - (pl_base + n * nsz);
        end
        return r;
    endfunction

    function automatic logic [63:0] min_u64(logic [63:0] a, logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic chunk_t plan_next_chunk(query_t q);
        chunk_t c;
        logic backward;
        logic [63:0] rend, nsz, len, cdst, csrc, rem;
        endpoint_t de, se;
        c = '0;
        backward = 1'b0;
        se.node = pl_local; se.remote = 1'b0; se.room = ALL_ONES;
        if (q.mode == MODE_NONE) return c;
        if (q.destination + q.xfer_len < q.destination) begin
            c.status = 1'b1;
            return c;
        end
        if (q.mode != MODE_SET) begin
            if (q.source + q.xfer_len < q.source) begin
                c.status = 1'b1;
                return c;
            end
            backward = (q.mode == MODE_MOVE) && (q.destination > q.source)
                && (q.destination < q.source + q.xfer_len);
        end
        if (q.completed >= q.xfer_len || pl_max == 32'd0) return c;
        if (pl_size == 64'd0 || pl_nodes == 16'd0 || pl_local >= pl_nodes) return c;
        rend = pl_base + pl_size;
        if (rend < pl_base) return c;
        nsz = pl_size / {48'd0, pl_nodes};
        if (nsz == 64'd0) return c;
        len = min_u64({32'd0, pl_max}, q.xfer_len - q.completed);
        if (!backward) begin
            cdst = q.destination + q.completed;
            csrc = 64'd0;
            de = reach_up(rend, nsz, cdst);
            if (q.mode != MODE_SET) begin
                csrc = q.source + q.completed;
                se = reach_up(rend, nsz, csrc);
            end
        end else begin
            rem = q.xfer_len - q.completed;
            de = reach_down(rend, nsz, q.destination + rem);
            se = reach_down(rend, nsz, q.source + rem);
        end
        len = min_u64(len, min_u64(de.room, se.room));
        if (backward) begin
            cdst = q.destination + rem - len;
            csrc = q.source + rem - len;
        end
        if (len == 64'd0 || len > 64'hFFFF_FFFF) return c;
        c.chunk_valid = 1'b1;
        c.chunk_destination = cdst;
        c.chunk_source = csrc;
        c.chunk_length = len[31:0];
        c.dst_node = de.node;
        c.src_node = se.node;
        c.dst_remote = de.remote;
        c.src_remote = se.remote;
        return c;
    endfunction

    // Sends one query beat and records its expected chunk; valid stays up for the next beat.
    task automatic send_query(query_t q);
        while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {6'd0, q};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_chunks.push_back(plan_next_chunk(q));
        @(negedge aclk);
    endtask

    // Writes one register; valid stays up for a following write.
    task automatic write_register(logic [2:0] index, logic [63:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            REG_REGION_BASE: pl_base = value;
            REG_REGION_SIZE: pl_size = value;
            REG_NODE_COUNT:  pl_nodes = value[15:0];
            REG_LOCAL_NODE:  pl_local = value[15:0];
            REG_MAX_CHUNK:   pl_max = value[31:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Stops sending and waits until every expected chunk has arrived.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_chunks.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic set_region(logic [63:0] base, logic [63:0] size, logic [15:0] nodes,
                              logic [15:0] local_id, logic [31:0] max_len);
        drain();
        write_register(REG_REGION_BASE, base);
        write_register(REG_REGION_SIZE, size);
        write_register(REG_NODE_COUNT, {48'd0, nodes});
        write_register(REG_LOCAL_NODE, {48'd0, local_id});
        write_register(REG_MAX_CHUNK, {32'd0, max_len});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic query_t make_query(logic [1:0] mode, logic [63:0] dst,
                                          logic [63:0] src, logic [63:0] total,
                                          logic [63:0] done);
        query_t q;
        q.mode = mode; q.destination = dst; q.source = src;
        q.xfer_len = total; q.completed = done;
        return q;
    endfunction

    // Mostly queries near the region with a transfer in progress.
    function automatic query_t random_query();
        logic [63:0] span, total;
        logic [1:0] mode;
        mode = $urandom_range(9) == 0 ? MODE_NONE : 2'($urandom_range(2));
        if ($urandom_range(9) == 0)
            return make_query(mode, rand64(), rand64(), rand64(), rand64());
        span = (pl_size == 0) ? 64'h1_0000 : pl_size;
        total = 64'($urandom_range(1, 300000));
        return make_query(mode,
            pl_base + 64'($urandom()) % (span + 64'd8192) - 64'd4096,
            $urandom_range(3) == 0
                ? pl_base + 64'($urandom()) % (span + 64'd8192) - 64'd4096
                : pl_base + 64'($urandom()) % (span + 64'd8192) - 64'($urandom_range(5000)),
            total,
            $urandom_range(7) == 0 ? total + 64'($urandom_range(1))
                                   : 64'($urandom()) % total);
    endfunction

    task automatic test_directed;
        set_region(64'h1000, 64'h4_0000, 16'd4, 16'd1, 32'h8000);
        send_query(make_query(MODE_SET, 64'h800, 64'h0, 64'h2000, 64'h0));
        send_query(make_query(MODE_COPY, 64'h1_0000, 64'h3_0000, 64'h2_0000, 64'h100));
        send_query(make_query(MODE_MOVE, 64'h2000, 64'h1800, 64'h4000, 64'h0));
        send_query(make_query(MODE_MOVE, 64'h1800, 64'h2000, 64'h4000, 64'h0));
        send_query(make_query(MODE_NONE, 64'h2000, 64'h2000, 64'h10, 64'h0));
        send_query(make_query(MODE_SET, ALL_ONES, 64'h0, 64'h2, 64'h0));
        send_query(make_query(MODE_COPY, 64'h0, ALL_ONES, 64'h2, 64'h0));
        send_query(make_query(MODE_COPY, 64'h2000, 64'h3000, 64'h100, 64'h100));
        send_query(make_query(MODE_COPY, 64'h50_0000, 64'h2000, 64'h100000, 64'h0));
        send_query(make_query(MODE_SET, 64'h3_FFFF, 64'h0, 64'h10, 64'h0));
        send_query(make_query(MODE_COPY, ALL_ONES, ALL_ONES, 64'h0, 64'h0));
        send_query(make_query(MODE_MOVE, 64'h4_0000, 64'h3_F000, 64'h4000, 64'h1000));
        send_query(make_query(MODE_MOVE, 64'h100, 64'h0, 64'h200, 64'h0));
        // Wide region with the largest 32-bit chunk limit and a transfer longer than 32 bits.
        set_region(64'h0, ALL_ONES, 16'd1, 16'd0, 32'hFFFF_FFFF);
        send_query(make_query(MODE_SET, 64'h0, 64'h0, ALL_ONES - 64'd1, 64'h0));
        send_query(make_query(MODE_COPY, ALL_ONES - 64'h10, 64'h5, 64'h10, 64'h3));
        // Invalid settings and the zero chunk limit.
        set_region(ALL_ONES, 64'h10, 16'd2, 16'd0, 32'h0);
        send_query(make_query(MODE_SET, 64'h0, 64'h0, 64'h10, 64'h0));
        set_region(64'h0, 64'h100, 16'd0, 16'd0, 32'h40);
        send_query(make_query(MODE_SET, 64'h0, 64'h0, 64'h10, 64'h0));
        set_region(64'h0, 64'h3, 16'hFFFF, 16'hFFFE, 32'h40);
        send_query(make_query(MODE_SET, 64'h0, 64'h0, 64'h10, 64'h0));
        set_region(ALL_ONES - 64'h1_0000, 64'h1_0000, 16'hFFFF, 16'hFFFF, 32'h40);
        send_query(make_query(MODE_COPY, ALL_ONES - 64'h8000, 64'h0, 64'h100, 64'h0));
        set_region(64'h0, ALL_ONES, 16'hFFFF, 16'h1234, 32'h1);
        send_query(make_query(MODE_COPY, ALL_ONES - 64'h2, ALL_ONES - 64'h9, 64'h2, 64'h1));
    endtask

    task automatic test_random(int count);
        repeat (count) send_query(random_query());
    endtask

    // Receiver holds off long enough for the pipeline to fill.
    task automatic test_backpressure;
        drain();
        hold_cycles = 200;
        test_random(80);
    endtask

    // Stimulus, with the idling schedule over three phases.
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        sender_idle = 15; receiver_idle = 75;
        set_region(64'h10_0000, 64'h40_0000, 16'd8, 16'd3, 32'h4000);
        test_random(240);
        sender_idle = 75; receiver_idle = 15;
        set_region(64'h0, 64'h30_0007, 16'd3, 16'd2, 32'h1_0000);
        test_random(240);
        sender_idle = 0; receiver_idle = 0;
        set_region(64'h8000_0000, 64'h1_0000, 16'd5, 16'd4, 32'h1000);
        test_random(220);
        test_backpressure();
        drain();
        if (mismatch_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    // Receiver ready, with random stalls or a long hold.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Compares each result beat with the oldest expected chunk.
    always @(posedge aclk) begin
        chunk_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = chunk_t'(m_tdata[195:0]);
            if (expected_chunks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_chunks.pop_front();
                if (got !== want || m_tdata[199:196] !== 4'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("chunk mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || hold_cycles > 0) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
